// ----- rtl/sfr_pkg.sv -----
// sfr_pkg: shared types and constants for the serial frame receiver
// holds the parser phase encoding, event codes and the result record
// no dependencies
`timescale 1ns / 1ps

package sfr_pkg;

    localparam logic [7:0] SYNC_BYTE    = 8'hFF;
    localparam logic [7:0] VERSION_BYTE = 8'hFE;

    // event codes carried on the result channel
    localparam logic [2:0] EV_DATA    = 3'd0;
    localparam logic [2:0] EV_GOOD    = 3'd1;
    localparam logic [2:0] EV_BADSUM  = 3'd2;
    localparam logic [2:0] EV_BADHDR  = 3'd3;
    localparam logic [2:0] EV_TOOLONG = 3'd4;

    // parser phases, one-hot
    typedef enum logic [8:0] {
        PH_HUNT     = 9'b000000001,
        PH_VERSION  = 9'b000000010,
        PH_LEN_LO   = 9'b000000100,
        PH_LEN_HI   = 9'b000001000,
        PH_LEN_CS   = 9'b000010000,
        PH_TOPIC_LO = 9'b000100000,
        PH_TOPIC_HI = 9'b001000000,
        PH_PAYLOAD  = 9'b010000000,
        PH_CHECKSUM = 9'b100000000
    } phase_t;

    // one result transaction
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  data_byte;
        logic [15:0] topic;
        logic [15:0] frame_len;
        logic [15:0] byte_index;
        logic        last;
    } result_t;

endpackage

// ----- rtl/serial_frame_receiver.sv -----
// serial_frame_receiver: top level of the byte-serial frame deframer
// depends on sfr_pkg, sfr_in_stage, sfr_parser and sfr_out_stage
`timescale 1ns / 1ps

// usage
// - slave channel: one received serial byte per transaction on s_tdata
// - master channel: one result per payload byte and one status result per
//   frame (good, checksum error, bad header, too long); m_tuser carries the
//   event code, m_tlast marks the status result that closes a frame
// - hunt bytes other than sync and bytes of a passing header make no transaction
// - cfg_wr_en / cfg_wr_data write the payload length limit; write only while
//   the block is idle, the new limit applies at the next length check
// - path: a byte accepted into the input register is stepped by the parser
//   into the result register
// - throughput: one byte per cycle while no result waits on m_tready; the parser
//   step between the input register and the result register is combinational
// - reset (aresetn low, synchronous): parser hunts for sync, both registers
//   empty, length limit back to 65535
// - stall: while a result waits on m_tready the parser holds; the input
//   register still takes a byte if it is empty, then s_tready drops
module serial_frame_receiver
    import sfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // received byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,     // [7:0] data_byte, [23:8] topic,
                                     // [39:24] frame_len, [55:40] byte_index
    output logic [2:0]  m_tuser,     // [2:0] event_res
    output logic        m_tlast      // last
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       consume;
    logic       out_free;
    logic       res_valid;
    result_t    res;
    result_t    m_res;

    // input register, frees as soon as the parser takes the byte
    sfr_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .consume  (consume),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    // parser only steps when the result register can take its output
    sfr_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .out_free    (out_free),
        .consume     (consume),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register, loaded only for bytes that produce a transaction
    sfr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (consume && res_valid),
        .res      (res),
        .m_tready (m_tready),
        .out_free (out_free),
        .m_valid  (m_tvalid),
        .m_res    (m_res)
    );

    // pack the result record onto the stream ports
    assign m_tdata = {m_res.byte_index, m_res.frame_len, m_res.topic, m_res.data_byte};
    assign m_tuser = m_res.event_res;
    assign m_tlast = m_res.last;

endmodule

// ----- rtl/sfr_in_stage.sv -----
// sfr_in_stage: input register for received bytes
// depends on nothing outside this file
`timescale 1ns / 1ps

module sfr_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       consume,
    output logic       in_valid,
    output logic [7:0] in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign s_tready   = !valid_reg || consume;
    assign load       = s_tvalid && s_tready;
    assign valid_next = load ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

// ----- rtl/sfr_parser.sv -----
// sfr_parser: frame state machine, header capture, checksums and length check
// uses sfr_pkg for phase encoding, event codes and the result record
`timescale 1ns / 1ps

module sfr_parser
    import sfr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic [7:0]  in_byte,
    input  logic        out_free,
    output logic        consume,
    output logic        res_valid,
    output result_t     res
);

    phase_t      phase_reg,   phase_next;
    logic        fault_reg,   fault_next;
    logic [15:0] len_reg,     len_next;
    logic [7:0]  lcheck_reg,  lcheck_next;
    logic [15:0] topic_reg,   topic_next;
    logic [15:0] count_reg,   count_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [15:0] max_len_reg;

    assign consume = in_valid && out_free;

    always_comb begin
        phase_next  = phase_reg;
        fault_next  = fault_reg;
        len_next    = len_reg;
        lcheck_next = lcheck_reg;
        topic_next  = topic_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        res_valid   = 1'b0;
        res         = '0;
        unique case (phase_reg)
            PH_VERSION: begin
                fault_next = (in_byte != VERSION_BYTE);
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_next    = {8'h00, in_byte};
                lcheck_next = in_byte;
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_next    = {in_byte, len_reg[7:0]};
                lcheck_next = lcheck_reg + in_byte;
                phase_next  = PH_LEN_CS;
            end
            PH_LEN_CS: begin
                if (~lcheck_reg != in_byte) begin
                    fault_next = 1'b1;
                end
                phase_next = PH_TOPIC_LO;
            end
            PH_TOPIC_LO: begin
                topic_next = {8'h00, in_byte};
                sum_next   = in_byte;
                phase_next = PH_TOPIC_HI;
            end
            PH_TOPIC_HI: begin
                topic_next = {in_byte, topic_reg[7:0]};
                sum_next   = sum_reg + in_byte;
                count_next = '0;
                res.topic     = {in_byte, topic_reg[7:0]};
                res.frame_len = len_reg;
                res.last      = 1'b1;
                // header fault takes priority over the length limit
                if (fault_reg) begin
                    phase_next    = PH_HUNT;
                    res_valid     = 1'b1;
                    res.event_res = EV_BADHDR;
                end else if (len_reg > max_len_reg) begin
                    phase_next    = PH_HUNT;
                    res_valid     = 1'b1;
                    res.event_res = EV_TOOLONG;
                end else begin
                    phase_next = (len_reg == '0) ? PH_CHECKSUM : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                sum_next       = sum_reg + in_byte;
                count_next     = count_reg + 16'd1;
                res_valid      = 1'b1;
                res.event_res  = EV_DATA;
                res.data_byte  = in_byte;
                res.topic      = topic_reg;
                res.frame_len  = len_reg;
                res.byte_index = count_reg;
                if (count_next >= len_reg) begin
                    phase_next = PH_CHECKSUM;
                end
            end
            PH_CHECKSUM: begin
                phase_next    = PH_HUNT;
                res_valid     = 1'b1;
                res.event_res = (~sum_reg == in_byte) ? EV_GOOD : EV_BADSUM;
                res.topic     = topic_reg;
                res.frame_len = len_reg;
                res.last      = 1'b1;
            end
            default: begin
                // hunting, and any unreachable code
                phase_next = (in_byte == SYNC_BYTE) ? PH_VERSION : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            fault_reg   <= 1'b0;
            len_reg     <= '0;
            lcheck_reg  <= '0;
            topic_reg   <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
        end else if (consume) begin
            phase_reg   <= phase_next;
            fault_reg   <= fault_next;
            len_reg     <= len_next;
            lcheck_reg  <= lcheck_next;
            topic_reg   <= topic_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= 16'hFFFF;
        end else if (cfg_wr_en) begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // a payload byte always produces a result
    a_payload_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && (phase_reg == PH_PAYLOAD) |-> res_valid)
        else $error("payload byte consumed without a result");

    // a frame-closing result sends the parser back to hunting
    a_last_rehunt: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && res_valid && res.last |=> (phase_reg == PH_HUNT))
        else $error("parser not hunting after frame close");

    // payload results stay inside the announced length and never close a frame
    a_data_index: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && (res.event_res == EV_DATA) |->
            !res.last && (res.byte_index < res.frame_len))
        else $error("payload result out of range");

endmodule

// ----- rtl/sfr_out_stage.sv -----
// sfr_out_stage: result register in front of the master channel
// uses sfr_pkg for the result record
`timescale 1ns / 1ps

module sfr_out_stage
    import sfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res,
    input  logic    m_tready,
    output logic    out_free,
    output logic    m_valid,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_free   = !valid_reg || m_tready;
    assign valid_next = load ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ----- tb/tb.sv -----
// tb: self-checking bench for serial_frame_receiver, byte stream in, event stream out
// clocked driver and monitor around a deframer predictor kept in step with accepted bytes
// depends on sfr_pkg and serial_frame_receiver
`timescale 1ns / 1ps

module tb;
    import sfr_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    serial_frame_receiver DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // deframer state as the block should hold it
    phase_t      frame_phase = PH_HUNT;
    logic        hdr_fault   = 1'b0;
    logic [15:0] len_field   = '0;
    logic [7:0]  len_sum     = '0;
    logic [15:0] topic_field = '0;
    logic [15:0] pay_count   = '0;
    logic [7:0]  pay_sum     = '0;
    logic [15:0] len_limit   = 16'hFFFF;

    result_t     deframe_events[$];
    logic [7:0]  rx_bytes[$];
    int          bytes_queued = 0;
    int          errors = 0;
    int          results_seen = 0;

    function automatic result_t make_event(input logic [2:0] ev, input logic [7:0] data,
                                           input logic [15:0] idx, input logic fin);
        result_t r;
        r.event_res  = ev;
        r.data_byte  = data;
        r.topic      = topic_field;
        r.frame_len  = len_field;
        r.byte_index = idx;
        r.last       = fin;
        return r;
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        logic [7:0] cs;
        case (frame_phase)
            PH_VERSION: begin
                hdr_fault   = (b != VERSION_BYTE);
                frame_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_field   = {8'h00, b};
                len_sum     = b;
                frame_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_field[15:8] = b;
                len_sum         = len_sum + b;
                frame_phase     = PH_LEN_CS;
            end
            PH_LEN_CS: begin
                cs = ~len_sum;
                if (cs != b) hdr_fault = 1'b1;
                frame_phase = PH_TOPIC_LO;
            end
            PH_TOPIC_LO: begin
                topic_field = {8'h00, b};
                pay_sum     = b;
                frame_phase = PH_TOPIC_HI;
            end
            PH_TOPIC_HI: begin
                topic_field[15:8] = b;
                pay_sum           = pay_sum + b;
                pay_count         = '0;
                // a bad header is reported ahead of an oversize length
                if (hdr_fault) begin
                    frame_phase = PH_HUNT;
                    deframe_events.push_back(make_event(EV_BADHDR, 8'h00, 16'h0000, 1'b1));
                end else if (len_field > len_limit) begin
                    frame_phase = PH_HUNT;
                    deframe_events.push_back(make_event(EV_TOOLONG, 8'h00, 16'h0000, 1'b1));
                end else begin
                    frame_phase = (len_field == 16'h0000) ? PH_CHECKSUM : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                pay_sum = pay_sum + b;
                deframe_events.push_back(make_event(EV_DATA, b, pay_count, 1'b0));
                pay_count = pay_count + 16'd1;
                if (pay_count >= len_field) frame_phase = PH_CHECKSUM;
            end
            PH_CHECKSUM: begin
                cs          = ~pay_sum;
                frame_phase = PH_HUNT;
                deframe_events.push_back(make_event((cs == b) ? EV_GOOD : EV_BADSUM,
                                                    8'h00, 16'h0000, 1'b1));
            end
            default: begin
                frame_phase = (b == SYNC_BYTE) ? PH_VERSION : PH_HUNT;
            end
        endcase
    endtask

    // byte driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
                void'(rx_bytes.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || rx_bytes.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_bytes[0];
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 24);
                        gap_left   = $urandom_range(1, 9);
                    end
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    int      rx_cycle   = 0;
    int      stall_mode = 0;
    int      hold_left  = 0;
    int      holds_done = 0;
    result_t want;

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (deframe_events.size() == 0) begin
                    $error("unexpected result transaction: event %0d", m_tuser);
                    errors++;
                end else begin
                    want = deframe_events.pop_front();
                    check_field("event_res",  want.event_res,  m_tuser);
                    check_field("data_byte",  want.data_byte,  m_tdata[7:0]);
                    check_field("topic",      want.topic,      m_tdata[23:8]);
                    check_field("frame_len",  want.frame_len,  m_tdata[39:24]);
                    check_field("byte_index", want.byte_index, m_tdata[55:40]);
                    check_field("last",       want.last,       m_tlast);
                end
            end
            rx_cycle++;
            if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 3);
            // long hold-offs so the block fills and backs up its input
            if (hold_left == 0 && ((holds_done == 0 && results_seen >= 100) ||
                                   (holds_done == 1 && results_seen >= 400))) begin
                hold_left = 400;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (rx_cycle % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_noise(input int n, input bit no_sync);
        logic [7:0] v;
        for (int i = 0; i < n; i++) begin
            v = 8'($urandom);
            if (no_sync && v == SYNC_BYTE) v = 8'h00;
            push_byte(v);
        end
    endtask

    // header, n_body payload bytes, then the checksum when tail is set
    task automatic push_frame(input logic [15:0] topic, input logic [15:0] len,
                              input bit bad_ver, input bit bad_lcs, input bit bad_sum,
                              input int n_body, input bit tail);
        logic [7:0] lcs;
        logic [7:0] sum;
        logic [7:0] v;
        push_byte(SYNC_BYTE);
        if (bad_ver) begin
            v = ($urandom_range(0, 1) == 0) ? SYNC_BYTE : 8'($urandom);
            if (v == VERSION_BYTE) v = 8'h00;
            push_byte(v);
        end else begin
            push_byte(VERSION_BYTE);
        end
        lcs = len[7:0] + len[15:8];
        lcs = ~lcs;
        if (bad_lcs) lcs = lcs ^ 8'($urandom_range(1, 255));
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        push_byte(lcs);
        push_byte(topic[7:0]);
        push_byte(topic[15:8]);
        sum = topic[7:0] + topic[15:8];
        for (int i = 0; i < n_body; i++) begin
            v   = 8'($urandom);
            sum = sum + v;
            push_byte(v);
        end
        if (tail) begin
            sum = ~sum;
            if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
            push_byte(sum);
        end
    endtask

    task automatic wait_idle();
        while (rx_bytes.size() != 0 || deframe_events.size() != 0) @(posedge aclk);
        // header bytes give no result, so let the pipeline drain
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        len_limit = v;
    endtask

    function automatic logic [15:0] pick_topic();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int n_bytes);
        int          stop_at;
        int          kind;
        logic [15:0] len;
        stop_at = bytes_queued + n_bytes;
        while (bytes_queued < stop_at) begin
            kind = $urandom_range(0, 99);
            len  = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(0, 8));
            if (len > len_limit) len = len_limit;
            if (kind < 65) begin
                push_frame(pick_topic(), len, 0, 0, 0, len, 1);
            end else if (kind < 75) begin
                push_frame(pick_topic(), len, 0, 0, 1, len, 1);
            end else if (kind < 80) begin
                push_frame(pick_topic(), len, 1, 1'($urandom_range(0, 1)), 0,
                           $urandom_range(0, 3), 0);
            end else if (kind < 85) begin
                push_frame(pick_topic(), len, 0, 1, 0, $urandom_range(0, 3), 0);
            end else if (kind < 90) begin
                if (len_limit != 16'hFFFF) begin
                    len = 16'($urandom_range(int'(len_limit) + 1, 65535));
                    push_frame(pick_topic(), len, 0, 0, 0, 0, 0);
                end else begin
                    push_frame(pick_topic(), len, 0, 0, 0, len, 1);
                end
            end else if (kind < 95) begin
                // cut short: the next sync lands inside the payload
                if (len == 0) len = 1;
                if (len <= len_limit) push_frame(pick_topic(), len, 0, 0, 0, len - 1, 0);
            end else begin
                push_noise($urandom_range(1, 6), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset limit: ignored hunt bytes, then good, bad sum and bad header
        push_byte(8'h00);
        push_byte(8'hFE);
        push_byte(8'h7F);
        push_byte(8'h80);
        push_frame(16'h0000, 16'd0, 0, 0, 0, 0, 1);
        push_frame(16'hFFFF, 16'd1, 0, 0, 0, 1, 1);
        push_frame(16'h1234, 16'd3, 0, 0, 1, 3, 1);
        push_frame(16'hA5A5, 16'd2, 1, 0, 0, 0, 0);
        push_frame(16'h5A5A, 16'd2, 0, 1, 0, 0, 0);
        wait_idle();

        // directed with a small limit: oversize, bad header beats oversize, limit edge
        write_limit(16'd4);
        push_frame(16'h00FF, 16'd5, 0, 0, 0, 0, 0);
        push_frame(16'hFF00, 16'd300, 1, 1, 0, 0, 0);
        push_frame(16'h8001, 16'd4, 0, 0, 0, 4, 1);
        push_frame(16'h7FFE, 16'd0, 0, 0, 1, 0, 1);
        wait_idle();

        write_limit(16'hFFFE);
        push_frame(16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0);
        random_phase(200);
        wait_idle();

        write_limit(16'd0);
        random_phase(180);
        wait_idle();

        write_limit(16'hFFFF);
        random_phase(220);
        wait_idle();

        write_limit(16'd1);
        random_phase(180);
        wait_idle();

        write_limit(16'($urandom_range(2, 30)));
        random_phase(190);
        wait_idle();

        write_limit(16'($urandom));
        random_phase(190);
        wait_idle();

        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS serial_frame_receiver");
        end else begin
            $display("FAIL serial_frame_receiver");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("FAIL serial_frame_receiver");
        $finish;
    end

endmodule
